// ===== rtl/core/bre_pkg.sv =====
package bre_pkg;

    localparam int DIVD_W = 36;
    localparam int DIVS_W = 20;
    localparam int DCNT_W = 6;

    localparam int CHARGE_MAX  = 100;
    localparam int PCT_DIV     = 100;
    localparam int GRAPH_MID   = 16000;
    localparam int GRAPH_SPAN  = 32000;
    localparam int MAX_OUT     = 32;

    localparam logic [12:0] RST_W_IDLE  = 13'd1000;
    localparam logic [12:0] RST_W_RX    = 13'd1450;
    localparam logic [12:0] RST_W_TX    = 13'd4200;
    localparam logic [15:0] RST_BASE    = 16'd960;
    localparam logic [15:0] RST_FSCALE  = 16'd1440;
    localparam logic [7:0]  RST_PERIOD  = 8'd15;
    localparam logic [7:0]  RST_MINSMP  = 8'd5;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_SNAP  = 2'd2;

    localparam logic [1:0] RADIO_RX = 2'd1;
    localparam logic [1:0] RADIO_TX = 2'd2;

    localparam logic [2:0] CFG_W_IDLE = 3'd0;
    localparam logic [2:0] CFG_W_RX   = 3'd1;
    localparam logic [2:0] CFG_W_TX   = 3'd2;
    localparam logic [2:0] CFG_BASE   = 3'd3;
    localparam logic [2:0] CFG_FSCALE = 3'd4;
    localparam logic [2:0] CFG_PERIOD = 3'd5;
    localparam logic [2:0] CFG_MINSMP = 3'd6;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } t_div_req;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_TICK_RD, S_TICK_UPD, S_AVG_START, S_AVG_WAIT,
        S_MUL1, S_MUL2, S_DIV2, S_DIV2_WAIT, S_GMUL, S_GDIV, S_GWAIT,
        S_GWR, S_SINIT, S_SRD, S_SOUT, S_SWAIT, S_ZERO
    } t_state;

endpackage

// ===== rtl/core/battery_runtime_estimator.sv =====
// Tick without graph point: updates window and counters. Start: two divider passes
// since the window is empty. Tick that stores a point: three passes. Either skips the
// graph pass if the full-scale config is zero. A tick before start runs a start
// first. Snapshot: estimate, then the result beats in turn, each held while stalled.
// One item at a time; not ready meanwhile. Synchronous active-low reset clears control,
// counters and config to defaults; window and graph memories are not cleared.
module battery_runtime_estimator #(
    parameter int WINDOW_DEPTH = 180,
    parameter int GRAPH_DEPTH  = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [6:0]         i_charge_percent,
    input  logic [1:0]         i_radio_status,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_initialized,
    output logic [6:0]         o_charge_level,
    output logic [31:0]        o_transmit_seconds,
    output logic [31:0]        o_receive_seconds,
    output logic [31:0]        o_powered_seconds,
    output logic [15:0]        o_remaining_minutes,
    output logic               o_estimate_valid,
    output logic [5:0]         o_graph_length,
    output logic [4:0]         o_graph_position,
    output logic signed [14:0] o_graph_value,
    output logic               o_last
);
    import bre_pkg::*;

    localparam int WPW = $clog2(WINDOW_DEPTH);
    localparam int GPW = GRAPH_DEPTH > 1 ? $clog2(GRAPH_DEPTH) : 1;
    localparam int GFW = $clog2(GRAPH_DEPTH + 1);

    // config
    logic [12:0] r_w_idle, r_w_rx, r_w_tx;
    logic [15:0] r_base, r_fscale;
    logic [7:0]  r_period, r_minsmp;

    // state
    t_state r_state, n_state;
    logic              r_started, r_tick_pend, r_snap;
    logic [6:0]        r_charge;
    logic [1:0]        r_radio;
    logic [WPW-1:0]    r_wpos;
    logic [7:0]        r_wfill;
    logic [20:0]       r_wsum;
    logic [31:0]       r_tx_cnt, r_rx_cnt, r_pw_cnt;
    logic [7:0]        r_pcnt;
    logic [GPW-1:0]    r_gwpos, r_gidx;
    logic [GFW-1:0]    r_gfill;
    logic [12:0]       r_avg;
    logic [DIVD_W-1:0] r_prod;
    logic [DIVS_W-1:0] r_den;
    logic [15:0]       r_rem, r_gq;
    logic [5:0]        r_n;
    logic [4:0]        r_i;
    logic              r_gzero;

    // output beat
    logic        r_ovalid, r_oinit, r_oest, r_olast;
    logic [6:0]  r_ochg;
    logic [31:0] r_otx, r_orx, r_opw;
    logic [15:0] r_orem;
    logic [5:0]  r_olen;
    logic [4:0]  r_opos;
    logic [14:0] r_oval;

    // strobes
    t_div_req        div_req;
    logic            div_done;
    logic [DIVD_W-1:0] div_quo;
    logic            win_we, g_we;
    logic [12:0]     win_rdata;
    logic [14:0]     g_rdata;
    logic [GPW-1:0]  g_raddr;

    logic        in_acc, out_acc;
    logic [6:0]  chg_clamped;
    logic [12:0] tick_w;
    logic        win_full;
    logic [7:0]  pcnt_inc;
    logic        push_now;
    logic [12:0] avg_q, avg_fix;
    logic [15:0] m_clip;
    logic [15:0] gv;
    logic [6:0]  fill_ext;
    logic [5:0]  n_raw, n_use;
    logic [7:0]  first8;

    assign in_acc      = i_valid && !o_stall;
    assign out_acc     = r_ovalid && !i_stall;
    assign o_stall     = r_state != S_IDLE;
    assign chg_clamped = i_charge_percent > 7'(CHARGE_MAX) ? 7'(CHARGE_MAX) : i_charge_percent;

    always_comb begin
        tick_w = r_w_idle;
        case (r_radio)
            RADIO_TX: tick_w = r_w_tx;
            RADIO_RX: tick_w = r_w_rx;
            default:  tick_w = r_w_idle;
        endcase
    end

    assign win_full = r_wfill >= 8'(WINDOW_DEPTH);
    assign pcnt_inc = r_pcnt + 8'd1;
    assign push_now = pcnt_inc >= r_period;

    // average: empty window or zero quotient falls back to idle weight, then to one
    assign avg_q   = div_quo[12:0];
    always_comb begin
        avg_fix = (r_wfill == 8'd0) ? r_w_idle : r_avg;
        if (avg_fix == 13'd0) begin
            avg_fix = r_w_idle;
        end
        if (avg_fix == 13'd0) begin
            avg_fix = 13'd1;
        end
    end

    assign m_clip   = r_rem > r_fscale ? r_fscale : r_rem;
    assign gv       = 16'(GRAPH_MID) - r_gq;
    assign fill_ext = 7'(r_gfill);
    assign n_raw    = fill_ext > 7'(MAX_OUT) ? 6'(MAX_OUT) : fill_ext[5:0];
    assign n_use    = (n_raw == 6'd0) ? 6'd1 : n_raw;
    assign first8   = (8'(r_gwpos) >= 8'(n_use)) ? 8'(r_gwpos) - 8'(n_use)
                    : 8'(r_gwpos) + 8'(GRAPH_DEPTH) - 8'(n_use);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_op)
                        OP_START: n_state = S_CLR;
                        OP_TICK:  n_state = r_started ? S_TICK_RD : S_CLR;
                        OP_SNAP:  n_state = r_started ? S_AVG_START : S_ZERO;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLR:       n_state = S_AVG_START;
            S_TICK_RD:   n_state = S_TICK_UPD;
            S_TICK_UPD:  n_state = push_now ? S_AVG_START : S_IDLE;
            S_AVG_START: n_state = (r_wfill == 8'd0) ? S_MUL1 : S_AVG_WAIT;
            S_AVG_WAIT:  n_state = div_done ? S_MUL1 : S_AVG_WAIT;
            S_MUL1:      n_state = S_MUL2;
            S_MUL2:      n_state = S_DIV2;
            S_DIV2:      n_state = S_DIV2_WAIT;
            S_DIV2_WAIT: n_state = div_done ? (r_snap ? S_SINIT : S_GMUL) : S_DIV2_WAIT;
            S_GMUL:      n_state = (r_fscale == 16'd0) ? S_GWR : S_GDIV;
            S_GDIV:      n_state = S_GWAIT;
            S_GWAIT:     n_state = div_done ? S_GWR : S_GWAIT;
            S_GWR:       n_state = r_tick_pend ? S_TICK_RD : S_IDLE;
            S_SINIT:     n_state = S_SRD;
            S_SRD:       n_state = S_SOUT;
            S_SOUT:      n_state = S_SWAIT;
            S_SWAIT: begin
                if (out_acc) begin
                    n_state = r_olast ? S_IDLE : S_SRD;
                end
            end
            S_ZERO:      n_state = S_SWAIT;
            default:     n_state = S_IDLE;
        endcase
    end

    // control strobes
    always_comb begin
        div_req = '0;
        win_we  = 1'b0;
        g_we    = 1'b0;
        case (r_state)
            S_AVG_START: begin
                div_req.start    = r_wfill != 8'd0;
                div_req.dividend = DIVD_W'(r_wsum);
                div_req.divisor  = DIVS_W'(r_wfill);
            end
            S_DIV2: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod;
                div_req.divisor  = r_den;
            end
            S_GDIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod;
                div_req.divisor  = DIVS_W'(r_fscale);
            end
            S_TICK_UPD: win_we = 1'b1;
            S_GWR:      g_we   = 1'b1;
            default: ;
        endcase
    end

    assign g_raddr = r_gidx;

    bre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    bre_ram #(.WIDTH(13), .DEPTH(WINDOW_DEPTH)) u_win (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_wpos),
        .i_wdata (tick_w),
        .i_raddr (r_wpos),
        .o_rdata (win_rdata)
    );

    bre_ram #(.WIDTH(15), .DEPTH(GRAPH_DEPTH)) u_graph (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (r_gwpos),
        .i_wdata (gv[14:0]),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    // config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_idle <= RST_W_IDLE;
            r_w_rx   <= RST_W_RX;
            r_w_tx   <= RST_W_TX;
            r_base   <= RST_BASE;
            r_fscale <= RST_FSCALE;
            r_period <= RST_PERIOD;
            r_minsmp <= RST_MINSMP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_W_IDLE: r_w_idle <= i_cfg_data[12:0];
                CFG_W_RX:   r_w_rx   <= i_cfg_data[12:0];
                CFG_W_TX:   r_w_tx   <= i_cfg_data[12:0];
                CFG_BASE:   r_base   <= i_cfg_data;
                CFG_FSCALE: r_fscale <= i_cfg_data;
                CFG_PERIOD: r_period <= i_cfg_data[7:0];
                CFG_MINSMP: r_minsmp <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_tick_pend <= 1'b0;
            r_snap      <= 1'b0;
            r_charge    <= '0;
            r_wpos      <= '0;
            r_wfill     <= '0;
            r_wsum      <= '0;
            r_tx_cnt    <= '0;
            r_rx_cnt    <= '0;
            r_pw_cnt    <= '0;
            r_pcnt      <= '0;
            r_gwpos     <= '0;
            r_gfill     <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_radio <= i_radio_status;
                        if (i_op == OP_START || i_op == OP_TICK) begin
                            r_charge <= chg_clamped;
                        end
                        r_tick_pend <= (i_op == OP_TICK) && !r_started;
                        r_snap      <= i_op == OP_SNAP;
                    end
                end
                S_CLR: begin
                    r_started <= 1'b1;
                    r_wpos    <= '0;
                    r_wfill   <= '0;
                    r_wsum    <= '0;
                    r_tx_cnt  <= '0;
                    r_rx_cnt  <= '0;
                    r_pw_cnt  <= '0;
                    r_pcnt    <= '0;
                    r_gwpos   <= '0;
                    r_gfill   <= '0;
                end
                S_TICK_UPD: begin
                    r_tick_pend <= 1'b0;
                    if (r_radio == RADIO_TX) begin
                        r_tx_cnt <= r_tx_cnt + 32'd1;
                    end else if (r_radio == RADIO_RX) begin
                        r_rx_cnt <= r_rx_cnt + 32'd1;
                    end
                    r_pw_cnt <= r_pw_cnt + 32'd1;
                    // drop the oldest weight once the window is full
                    r_wsum <= r_wsum - (win_full ? 21'(win_rdata) : 21'd0) + 21'(tick_w);
                    if (!win_full) begin
                        r_wfill <= r_wfill + 8'd1;
                    end
                    r_wpos <= (r_wpos == WPW'(WINDOW_DEPTH - 1)) ? '0 : r_wpos + 1'b1;
                    r_pcnt <= push_now ? 8'd0 : pcnt_inc;
                end
                S_AVG_WAIT: begin
                    if (div_done) begin
                        r_avg <= avg_q;
                    end
                end
                S_MUL1: begin
                    r_prod <= DIVD_W'({16'd0, r_charge} * {7'd0, r_base});
                    r_den  <= DIVS_W'(avg_fix) * DIVS_W'(PCT_DIV);
                end
                S_MUL2: r_prod <= {13'd0, r_prod[22:0]} * {23'd0, r_w_idle};
                S_DIV2_WAIT: begin
                    if (div_done) begin
                        r_rem <= (div_quo > DIVD_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
                    end
                end
                S_GMUL: begin
                    r_prod <= DIVD_W'({15'd0, m_clip} * 31'(GRAPH_SPAN));
                    r_gq   <= '0;
                end
                S_GWAIT: begin
                    if (div_done) begin
                        r_gq <= div_quo[15:0];
                    end
                end
                S_GWR: begin
                    r_gwpos <= (r_gwpos == GPW'(GRAPH_DEPTH - 1)) ? '0 : r_gwpos + 1'b1;
                    if (r_gfill < GFW'(GRAPH_DEPTH)) begin
                        r_gfill <= r_gfill + 1'b1;
                    end
                end
                S_SINIT: begin
                    r_n     <= n_use;
                    r_i     <= '0;
                    r_gidx  <= GPW'(first8);
                    r_gzero <= n_raw == 6'd0;
                end
                S_SOUT: begin
                    r_ovalid <= 1'b1;
                    r_oinit  <= 1'b1;
                    r_ochg   <= r_charge;
                    r_otx    <= r_tx_cnt;
                    r_orx    <= r_rx_cnt;
                    r_opw    <= r_pw_cnt;
                    r_orem   <= r_rem;
                    r_oest   <= r_wfill >= r_minsmp;
                    r_olen   <= r_n;
                    r_opos   <= r_i;
                    r_oval   <= r_gzero ? 15'd0 : g_rdata;
                    r_olast  <= 6'(r_i) + 6'd1 == r_n;
                end
                S_ZERO: begin
                    r_ovalid <= 1'b1;
                    r_oinit  <= 1'b0;
                    r_ochg   <= '0;
                    r_otx    <= '0;
                    r_orx    <= '0;
                    r_opw    <= '0;
                    r_orem   <= '0;
                    r_oest   <= 1'b0;
                    r_olen   <= '0;
                    r_opos   <= '0;
                    r_oval   <= '0;
                    r_olast  <= 1'b1;
                end
                S_SWAIT: begin
                    if (out_acc) begin
                        r_ovalid <= 1'b0;
                        r_i      <= r_i + 5'd1;
                        r_gidx   <= (r_gidx == GPW'(GRAPH_DEPTH - 1)) ? '0 : r_gidx + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid             = r_ovalid;
    assign o_initialized       = r_oinit;
    assign o_charge_level      = r_ochg;
    assign o_transmit_seconds  = r_otx;
    assign o_receive_seconds   = r_orx;
    assign o_powered_seconds   = r_opw;
    assign o_remaining_minutes = r_orem;
    assign o_estimate_valid    = r_oest;
    assign o_graph_length      = r_olen;
    assign o_graph_position    = r_opos;
    assign o_graph_value       = r_oval;
    assign o_last              = r_olast;
endmodule

// ===== rtl/core/bre_ram.sv =====
module bre_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/bre_div.sv =====
module bre_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bre_pkg::t_div_req             i_req,
    output logic                          o_done,
    output logic [bre_pkg::DIVD_W-1:0]    o_quo
);
    import bre_pkg::*;

    logic [DIVS_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_quo;
    logic [DIVS_W-1:0] r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   shifted;
    logic              ge;

    assign shifted = {r_rem, r_quo[DIVD_W-1]};
    assign ge      = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_den  <= i_req.divisor;
                r_cnt  <= DCNT_W'(DIVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // one quotient bit per cycle, restoring
                r_rem <= ge ? DIVS_W'(shifted - {1'b0, r_den}) : shifted[DIVS_W-1:0];
                r_quo <= {r_quo[DIVD_W-2:0], ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// ===== rtl/core/bre_checker.sv =====
module bre_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic               o_initialized,
    input logic [5:0]         o_graph_length,
    input logic [4:0]         o_graph_position,
    input logic signed [14:0] o_graph_value,
    input logic               o_last
);
    // a pending beat holds across stall
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_graph_value))
        else $error("result beat dropped or changed under stall");

    // no new item while a result waits
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input taken while result pending");

    a_uninit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_initialized |-> o_last && o_graph_length == 6'd0)
        else $error("uninitialized snapshot not a single beat");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_initialized |->
            (o_last == (6'(o_graph_position) + 6'd1 == o_graph_length)))
        else $error("last flag does not match position");
endmodule

bind battery_runtime_estimator bre_checker u_bre_checker (.*);
